// ----- hdl/cpsg_pkg.sv -----
// shared types, constants and table functions for the cosine profile setpoint generator
package cpsg_pkg;

   localparam int CPSG_TABLE_DEPTH = 1024;
   localparam int PROG_W = 17;
   localparam int REM_W = 53;
   localparam int DIV_STEPS = 16;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam logic [63:0] CPSG_PI_Q30 = 64'd3373259426;
   localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
   localparam logic [20:0] TIME_SCALE = 21'd2000000;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_VELOCITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_VELOCITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_DISTANCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD_US = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_THRESHOLD = 3'd4;

   localparam logic [19:0] FULL_VELOCITY_RST = 20'd200000;
   localparam logic [19:0] SHORT_VELOCITY_RST = 20'd60000;
   localparam logic [30:0] SHORT_DISTANCE_RST = 31'd10000;
   localparam logic [19:0] TICK_PERIOD_US_RST = 20'd1000;
   localparam logic [15:0] SETTLE_THRESHOLD_RST = 16'd50;

   typedef struct packed {
      logic signed [31:0] goal_position;
      logic signed [31:0] measured_position;
      logic               drive_operational;
   } req_type;

   typedef struct packed {
      logic signed [31:0] setpoint;
      logic               moving;
      logic               arrived;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_LATCH,
      ST_PREP,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_IDX,
      ST_READ,
      ST_OFF,
      ST_SUM,
      ST_CHECK,
      ST_OUT
   } state_type;

   // q30 taylor cosine, angle in [0, pi/2]
   function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2 = (x * x) >> 30;
      term = 64'(ONE_Q30);
      sum = ONE_Q30;
      for (int k = 1; k <= 10; k++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * k - 1) * (2 * k));
         if ((k & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return sum;
   endfunction

   // q16 progress (1 - cos) / 2, rounded and clamped
   function automatic logic [PROG_W-1:0] progress_value(input logic [63:0] angle,
                                                        input logic flip);
      logic signed [63:0] c;
      logic signed [63:0] v;
      c = cos_q30(angle);
      if (flip) begin
         c = -c;
      end
      v = (ONE_Q30 - c + 64'sd16384) >>> 15;
      if (v < 64'sd0) begin
         v = 64'sd0;
      end else if (v > 64'sd65536) begin
         v = 64'sd65536;
      end
      return PROG_W'(v);
   endfunction

endpackage

// ----- hdl/cosine_profile_setpoint_generator_core.sv -----
// top level of the cosine profile position setpoint generator
//
// one request per interpolation tick carries the goal position, the measured
// position and the drive operational flag; one response carries the setpoint,
// the moving flag and the arrived flag. requests and responses use valid and
// ready; the csr channel writes the five profile registers and is always ready.
// after reset the progress table is copied into its ram with req_ready low;
// csr writes are taken during that pass. a request with the drive not
// operational goes straight to the output stage; when normalized time is
// already clamped to one the divide is skipped, and otherwise the quotient
// comes from the 16 restoring steps of the shared subtract unit. one request
// is worked at a time, so the next is accepted only after the last is through.
// the result sits in an output register: when the receiver stalls, the block
// finishes its current request and holds it in the output stage while a
// response is still waiting, then accepts again.
module cosine_profile_setpoint_generator_core import cpsg_pkg::*; #(
   parameter int TABLE_DEPTH = CPSG_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = PROG_W + AW + 1;

   state_type state_ff, state_in;

   logic [AW-1:0] fill_cnt_ff, fill_cnt_in;

   logic [19:0] full_vel_ff;
   logic [19:0] short_vel_ff;
   logic [30:0] short_dist_ff;
   logic [19:0] tick_ff;
   logic [15:0] settle_ff;

   req_type            req_ff, req_in;
   logic signed [31:0] start_ff, start_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic               in_move_ff, in_move_in;
   logic [19:0]        vel_ff, vel_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [31:0]        dist_ff, dist_in;
   logic [51:0]        num_ff, num_in;
   logic [REM_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   r_ff, r_in;
   logic [16:0]        tq_ff, tq_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [31:0]        off_ff, off_in;
   logic signed [31:0] sp_ff, sp_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [PROG_W-1:0] rom_data [TABLE_DEPTH];
   logic [PROG_W-1:0] prog;

   logic               out_free;
   logic signed [32:0] latch_diff;
   logic [31:0]        latch_dist;
   logic signed [32:0] cur_diff;
   logic [31:0]        cur_dist;
   logic [32:0]        elapsed_sum;
   logic [REM_W:0]     alu_a;
   logic [REM_W:0]     alu_diff;
   logic               alu_ge;
   logic [IW-1:0]      idx_full;
   logic [IW-1:0]      idx_shift;
   logic [48:0]        off_prod;
   logic [33:0]        sp_sum;
   logic signed [32:0] err_diff;
   logic [31:0]        err_mag;

   // constant cosine ramp, copied into the ram after reset
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
      localparam bit FLIP = (2 * g > TABLE_DEPTH - 1);
      localparam int FOLD = FLIP ? (TABLE_DEPTH - 1 - g) : g;
      localparam logic [63:0] ANGLE = (CPSG_PI_Q30 * 64'(FOLD)) / 64'(TABLE_DEPTH - 1);
      assign rom_data[g] = progress_value(ANGLE, FLIP);
   end

   cpsg_ram #(
      .WIDTH (PROG_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (state_ff == ST_FILL),
      .wr_addr (fill_cnt_ff),
      .wr_data (rom_data[fill_cnt_ff]),
      .rd_addr (idx_ff),
      .rd_data (prog)
   );

   assign alu_a = (state_ff == ST_DIV) ? {r_ff, 1'b0} : {{(REM_W + 1 - 52){1'b0}}, num_ff};

   cpsg_alu u_alu (
      .a    (alu_a),
      .b    (den_ff),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign out_free = ~rsp_valid_ff | rsp_ready;

   assign latch_diff = {req_ff.goal_position[31], req_ff.goal_position}
                     - {req_ff.measured_position[31], req_ff.measured_position};
   assign latch_dist = latch_diff[32] ? 32'(-latch_diff) : latch_diff[31:0];
   assign cur_diff = {req_ff.goal_position[31], req_ff.goal_position}
                   - {start_ff[31], start_ff};
   assign cur_dist = cur_diff[32] ? 32'(-cur_diff) : cur_diff[31:0];
   assign elapsed_sum = {1'b0, elapsed_ff} + {13'd0, tick_ff};

   assign idx_full = IW'(tq_ff) * IW'(TABLE_DEPTH - 1) + IW'(32768);
   assign idx_shift = idx_full >> 16;
   assign off_prod = 49'(dist_ff) * 49'(prog);
   assign sp_sum = diff_ff[32] ? ({start_ff[31], start_ff[31], start_ff} - {2'b00, off_ff})
                               : ({start_ff[31], start_ff[31], start_ff} + {2'b00, off_ff});
   assign err_diff = {req_ff.goal_position[31], req_ff.goal_position} - {sp_ff[31], sp_ff};
   assign err_mag = err_diff[32] ? 32'(-err_diff) : err_diff[31:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (fill_cnt_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: state_in = req_ff.drive_operational ? ST_PREP : ST_OUT;
         ST_PREP:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_CMP;
         ST_CMP:   state_in = alu_ge ? ST_IDX : ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX:   state_in = ST_READ;
         ST_READ:  state_in = ST_OFF;
         ST_OFF:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_CHECK;
         ST_CHECK: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      req_in = req_ff;
      start_in = start_ff;
      elapsed_in = elapsed_ff;
      in_move_in = in_move_ff;
      vel_in = vel_ff;
      diff_in = diff_ff;
      dist_in = dist_ff;
      num_in = num_ff;
      den_in = den_ff;
      r_in = r_ff;
      tq_in = tq_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      sp_in = sp_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_FILL: begin
            fill_cnt_in = fill_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            req_in = req_data;
         end
         ST_LATCH: begin
            res_in.setpoint = req_ff.measured_position;
            res_in.moving = in_move_ff;
            res_in.arrived = 1'b0;
            if (req_ff.drive_operational && !in_move_ff) begin
               start_in = req_ff.measured_position;
               in_move_in = 1'b1;
               vel_in = (latch_dist < 32'(short_dist_ff)) ? short_vel_ff : full_vel_ff;
            end
         end
         ST_PREP: begin
            diff_in = cur_diff;
            dist_in = cur_dist;
            elapsed_in = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
         end
         ST_MUL: begin
            num_in = 52'(elapsed_ff) * 52'(vel_ff);
            den_in = REM_W'(dist_ff) * REM_W'(TIME_SCALE);
         end
         ST_CMP: begin
            step_in = '0;
            r_in = REM_W'(num_ff);
            tq_in = alu_ge ? 17'h1_0000 : 17'd0;
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            tq_in = {tq_ff[15:0], alu_ge};
            r_in = alu_ge ? alu_diff[REM_W-1:0] : {r_ff[REM_W-2:0], 1'b0};
         end
         ST_IDX: begin
            idx_in = (idx_shift > IW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                       : idx_shift[AW-1:0];
         end
         ST_READ: begin
         end
         ST_OFF: begin
            off_in = off_prod[47:16];
         end
         ST_SUM: begin
            sp_in = sp_sum[31:0];
         end
         ST_CHECK: begin
            if (err_mag < 32'(settle_ff)) begin
               res_in.setpoint = req_ff.goal_position;
               res_in.moving = 1'b0;
               res_in.arrived = 1'b1;
               in_move_in = 1'b0;
               elapsed_in = '0;
            end else begin
               res_in.setpoint = sp_ff;
               res_in.moving = 1'b1;
               res_in.arrived = 1'b0;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_cnt_ff <= '0;
         start_ff <= '0;
         elapsed_ff <= '0;
         in_move_ff <= 1'b0;
         vel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_cnt_ff <= fill_cnt_in;
         start_ff <= start_in;
         elapsed_ff <= elapsed_in;
         in_move_ff <= in_move_in;
         vel_ff <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      diff_ff <= diff_in;
      dist_ff <= dist_in;
      num_ff <= num_in;
      den_ff <= den_in;
      r_ff <= r_in;
      tq_ff <= tq_in;
      step_ff <= step_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      sp_ff <= sp_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // profile registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_vel_ff <= FULL_VELOCITY_RST;
         short_vel_ff <= SHORT_VELOCITY_RST;
         short_dist_ff <= SHORT_DISTANCE_RST;
         tick_ff <= TICK_PERIOD_US_RST;
         settle_ff <= SETTLE_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FULL_VELOCITY:    full_vel_ff <= csr_data[19:0];
            CSR_SHORT_VELOCITY:   short_vel_ff <= csr_data[19:0];
            CSR_SHORT_DISTANCE:   short_dist_ff <= csr_data[30:0];
            CSR_TICK_PERIOD_US:   tick_ff <= csr_data[19:0];
            CSR_SETTLE_THRESHOLD: settle_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_hold_when_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LATCH && !req_ff.drive_operational)
         |=> (in_move_ff == $past(in_move_ff)) && (elapsed_ff == $past(elapsed_ff)))
      else $error("state changed on a non-operational request");

   a_arrived_not_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.arrived && rsp_data.moving))
      else $error("response flags arrived and moving together");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (r_ff < den_ff) && !tq_ff[16])
      else $error("divide remainder out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule

// ----- hdl/cpsg_ram.sv -----
// generic single write port ram with registered read
module cpsg_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cpsg_alu.sv -----
// shared subtract and compare unit for the ratio compare and restoring divide steps
module cpsg_alu import cpsg_pkg::*; (
   input  logic [REM_W:0]   a,
   input  logic [REM_W-1:0] b,
   output logic [REM_W:0]   diff,
   output logic             ge
);

   logic [REM_W+1:0] full;

   assign full = {1'b0, a} - {2'b00, b};
   assign diff = full[REM_W:0];
   assign ge = ~full[REM_W+1];

endmodule
